FILE: hdl/fbsf_pkg.sv
// ============================================================================
// fbsf_pkg: shared types and constants of the frame-store blit engine
// Command codes, register indexes, controller states and the command/status
// bundles that join the controller to the datapath.
// ============================================================================
package fbsf_pkg;

    // Default frame-store geometry (row stride and row count)
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Field widths
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 11;
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 3 * CHAN_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    // Reset value of both screen registers
    localparam logic [CFG_W-1:0] SCREEN_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_FILL   = 2'd2,
        OP_SCROLL = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SELECT,
        ST_CLIP,
        ST_DISPATCH,
        ST_COPY,
        ST_FILL,
        ST_READ,
        ST_READ_WAIT,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // latch an accepted input word
        logic select;      // form the raw rectangle and the copy plan
        logic clip;        // clip the rectangle to the screen
        logic res_init;    // open the result (zero colour, empty flag)
        logic init_copy;   // load the counters for the row copy
        logic init_fill;   // load the counters for the rectangle walk
        logic copy_step;   // move one pixel and advance
        logic fill_step;   // paint one pixel and advance
        logic cap_read;    // take the read colour into the result
        logic clear_step;  // zero one store entry during the sweep
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic empty;
        logic is_read;
        logic has_copy;
        logic last;
    } dp_status_t;

endpackage

FILE: hdl/fbsf_ram.sv
// ============================================================================
// fbsf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (read-first).
// ============================================================================
module fbsf_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/fbsf_ctrl.sv
// ============================================================================
// fbsf_ctrl: command sequencer of the blit engine
// Runs the clearing sweep, takes one word at a time, steps the datapath
// through plan, copy, fill or read, and presents the result word.
// ============================================================================
module fbsf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  fbsf_pkg::dp_status_t   status,
    output fbsf_pkg::ctrl_cmd_t    cmd
);

    fbsf_pkg::state_t state_reg;
    fbsf_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbsf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbsf_pkg::ST_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = fbsf_pkg::ST_IDLE;
                end
            end
            fbsf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fbsf_pkg::ST_SELECT;
                end
            end
            fbsf_pkg::ST_SELECT:
            begin
                state_next = fbsf_pkg::ST_CLIP;
            end
            fbsf_pkg::ST_CLIP:
            begin
                state_next = fbsf_pkg::ST_DISPATCH;
            end
            fbsf_pkg::ST_DISPATCH:
            begin
                if (status.empty)
                begin
                    state_next = fbsf_pkg::ST_RESULT;
                end
                else if (status.has_copy)
                begin
                    state_next = fbsf_pkg::ST_COPY;
                end
                else if (status.is_read)
                begin
                    state_next = fbsf_pkg::ST_READ;
                end
                else
                begin
                    state_next = fbsf_pkg::ST_FILL;
                end
            end
            fbsf_pkg::ST_COPY:
            begin
                if (status.last)
                begin
                    state_next = fbsf_pkg::ST_FILL;
                end
            end
            fbsf_pkg::ST_FILL:
            begin
                if (status.last)
                begin
                    state_next = fbsf_pkg::ST_RESULT;
                end
            end
            fbsf_pkg::ST_READ:
            begin
                state_next = fbsf_pkg::ST_READ_WAIT;
            end
            fbsf_pkg::ST_READ_WAIT:
            begin
                state_next = fbsf_pkg::ST_RESULT;
            end
            fbsf_pkg::ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = fbsf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbsf_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive the datapath commands and the handshakes
    always_comb
    begin
        cmd       = '0;
        in_stall  = (state_reg != fbsf_pkg::ST_IDLE);
        out_valid = (state_reg == fbsf_pkg::ST_RESULT);
        case (state_reg)
            fbsf_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            fbsf_pkg::ST_IDLE:
            begin
                cmd.load = in_valid;
            end
            fbsf_pkg::ST_SELECT:
            begin
                cmd.select = 1'b1;
            end
            fbsf_pkg::ST_CLIP:
            begin
                cmd.clip = 1'b1;
            end
            fbsf_pkg::ST_DISPATCH:
            begin
                cmd.res_init  = 1'b1;
                cmd.init_copy = !status.empty && status.has_copy;
                cmd.init_fill = !status.empty && !status.has_copy;
            end
            fbsf_pkg::ST_COPY:
            begin
                // The uncovered rows follow the last copied pixel
                cmd.copy_step = 1'b1;
                cmd.init_fill = status.last;
            end
            fbsf_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            fbsf_pkg::ST_READ_WAIT:
            begin
                cmd.cap_read = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/fbsf_datapath.sv
// ============================================================================
// fbsf_datapath: planning, clipping, pixel counters and store access
// Holds the screen registers and the accepted word, turns each command into
// an optional row copy plus a clipped rectangle, walks it one pixel a cycle
// and drives the frame-store ports through a one-deep write stage.
// ============================================================================
module fbsf_datapath #(
    parameter int MAX_WIDTH  = fbsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port
    input  logic                                  cfg_write,
    input  logic [fbsf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fbsf_pkg::CFG_W-1:0]            cfg_data,
    // Input word
    input  logic [1:0]                            command,
    input  logic signed [fbsf_pkg::COORD_W-1:0]   left_or_x,
    input  logic signed [fbsf_pkg::COORD_W-1:0]   top_or_y,
    input  logic signed [fbsf_pkg::COORD_W-1:0]   right_edge,
    input  logic signed [fbsf_pkg::COORD_W-1:0]   bottom_edge,
    input  logic signed [fbsf_pkg::COORD_W-1:0]   scroll_rows,
    input  logic [fbsf_pkg::CHAN_W-1:0]           red,
    input  logic [fbsf_pkg::CHAN_W-1:0]           green,
    input  logic [fbsf_pkg::CHAN_W-1:0]           blue,
    // Result word
    output logic [fbsf_pkg::CHAN_W-1:0]           read_red,
    output logic [fbsf_pkg::CHAN_W-1:0]           read_green,
    output logic [fbsf_pkg::CHAN_W-1:0]           read_blue,
    output logic                                  was_clipped_empty,
    // Controller link
    input  fbsf_pkg::ctrl_cmd_t                   cmd,
    output fbsf_pkg::dp_status_t                  status,
    // Frame store
    output logic                                  ram_we,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ram_waddr,
    output logic [fbsf_pkg::PIXEL_W-1:0]          ram_wdata,
    output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] ram_raddr,
    input  logic [fbsf_pkg::PIXEL_W-1:0]          ram_rdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = (fbsf_pkg::CFG_W > XW) ? fbsf_pkg::CFG_W : XW;
    localparam int CH    = (fbsf_pkg::CFG_W > YW) ? fbsf_pkg::CFG_W : YW;
    localparam int MXY   = (XW > YW) ? XW : YW;
    localparam int SW    = ((MXY > fbsf_pkg::COORD_W) ? MXY : fbsf_pkg::COORD_W) + 1;

    localparam logic signed [SW-1:0] S_ZERO = '0;
    localparam logic signed [SW-1:0] S_ONE  = SW'(1);

    // Screen registers
    logic [fbsf_pkg::CFG_W-1:0] width_reg;
    logic [fbsf_pkg::CFG_W-1:0] height_reg;

    // Accepted word
    fbsf_pkg::op_t                        op_reg;
    logic signed [fbsf_pkg::COORD_W-1:0]  lx_reg;
    logic signed [fbsf_pkg::COORD_W-1:0]  ty_reg;
    logic signed [fbsf_pkg::COORD_W-1:0]  re_reg;
    logic signed [fbsf_pkg::COORD_W-1:0]  be_reg;
    logic signed [fbsf_pkg::COORD_W-1:0]  rows_reg;
    logic [fbsf_pkg::PIXEL_W-1:0]         colour_reg;

    // Plan, after the select step
    logic signed [SW-1:0] rl_reg, rr_reg, rt_reg, rb_reg;
    logic signed [SW-1:0] rl_next, rr_next, rt_next, rb_next;
    logic                 has_copy_reg, has_copy_next;
    logic                 copy_down_reg, copy_down_next;
    logic [YW-1:0]        copy_y_first_reg, copy_y_first_next;
    logic [YW-1:0]        copy_y_last_reg, copy_y_last_next;
    logic [YW-1:0]        copy_src_first_reg, copy_src_first_next;
    logic [XW-1:0]        cx_last_reg;

    // Clipped rectangle
    logic                 empty_reg, empty_next;
    logic [XW-1:0]        fx_first_reg, fx_last_reg;
    logic [YW-1:0]        fy_first_reg, fy_last_reg;
    logic signed [SW-1:0] cl, cr, ct, cb;

    // Pixel counters
    logic [XW-1:0]        x_reg, x_first_reg, x_last_reg;
    logic [YW-1:0]        y_reg, src_y_reg, y_last_reg;
    logic                 down_reg;

    // Write stage and clearing sweep
    logic                 wr_en_reg;
    logic                 wr_from_ram_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [fbsf_pkg::PIXEL_W-1:0] wr_data_reg;
    logic [AW-1:0]        clear_addr_reg;

    // Result
    logic [fbsf_pkg::PIXEL_W-1:0] res_colour_reg;
    logic                 res_empty_reg;

    logic [XW-1:0]        uw;
    logic [YW-1:0]        uh;
    logic signed [SW-1:0] uw_s, uh_s;
    logic signed [SW-1:0] lx_s, ty_s, re_s, be_s, d_s;
    logic                 big;
    logic                 step;
    logic                 row_end;

    function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
        pix_addr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // Write the screen registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= fbsf_pkg::SCREEN_RESET;
            height_reg <= fbsf_pkg::SCREEN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fbsf_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                fbsf_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:                     width_reg  <= width_reg;
            endcase
        end
    end

    // Limit the screen to the store geometry
    always_comb
    begin
        uw   = (CW'(width_reg) > CW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_reg);
        uh   = (CH'(height_reg) > CH'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(height_reg);
        uw_s = $signed(SW'(uw));
        uh_s = $signed(SW'(uh));
    end

    // Latch the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= fbsf_pkg::op_t'(command);
            lx_reg     <= left_or_x;
            ty_reg     <= top_or_y;
            re_reg     <= right_edge;
            be_reg     <= bottom_edge;
            rows_reg   <= scroll_rows;
            colour_reg <= {red, green, blue};
        end
    end

    // Form the raw rectangle and the row-copy plan
    always_comb
    begin
        lx_s = SW'(lx_reg);
        ty_s = SW'(ty_reg);
        re_s = SW'(re_reg);
        be_s = SW'(be_reg);
        d_s  = SW'(rows_reg);
        big  = (d_s >= uh_s) || (d_s <= -uh_s);

        rl_next = lx_s;
        rr_next = lx_s + S_ONE;
        rt_next = ty_s;
        rb_next = ty_s + S_ONE;
        case (op_reg)
            fbsf_pkg::OP_WRITE, fbsf_pkg::OP_READ:
            begin
                rl_next = lx_s;
                rr_next = lx_s + S_ONE;
                rt_next = ty_s;
                rb_next = ty_s + S_ONE;
            end
            fbsf_pkg::OP_FILL:
            begin
                rl_next = lx_s;
                rr_next = re_s;
                rt_next = ty_s;
                rb_next = be_s;
            end
            fbsf_pkg::OP_SCROLL:
            begin
                // Uncovered rows: all of them, the top band or the bottom band
                rl_next = S_ZERO;
                rr_next = uw_s;
                if (big)
                begin
                    rt_next = S_ZERO;
                    rb_next = uh_s;
                end
                else if (d_s > S_ZERO)
                begin
                    rt_next = S_ZERO;
                    rb_next = d_s;
                end
                else
                begin
                    rt_next = uh_s + d_s;
                    rb_next = uh_s;
                end
            end
            default:
            begin
                rl_next = lx_s;
            end
        endcase

        has_copy_next  = (op_reg == fbsf_pkg::OP_SCROLL) && !big &&
                         (d_s != S_ZERO) && (uw != '0);
        copy_down_next = (d_s > S_ZERO);
        // Down: bottom row first; up: top row first
        copy_y_first_next   = copy_down_next ? YW'(uh_s - S_ONE) : '0;
        copy_y_last_next    = copy_down_next ? YW'(d_s) : YW'(uh_s + d_s - S_ONE);
        copy_src_first_next = copy_down_next ? YW'(uh_s - S_ONE - d_s) : YW'(-d_s);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            rl_reg             <= rl_next;
            rr_reg             <= rr_next;
            rt_reg             <= rt_next;
            rb_reg             <= rb_next;
            has_copy_reg       <= has_copy_next;
            copy_down_reg      <= copy_down_next;
            copy_y_first_reg   <= copy_y_first_next;
            copy_y_last_reg    <= copy_y_last_next;
            copy_src_first_reg <= copy_src_first_next;
            cx_last_reg        <= uw - XW'(1);
        end
    end

    // Clip the rectangle to the screen
    always_comb
    begin
        cl = (rl_reg < S_ZERO) ? S_ZERO : rl_reg;
        cr = (rr_reg > uw_s) ? uw_s : rr_reg;
        ct = (rt_reg < S_ZERO) ? S_ZERO : rt_reg;
        cb = (rb_reg > uh_s) ? uh_s : rb_reg;
        empty_next = (cl >= cr) || (ct >= cb);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clip)
        begin
            empty_reg    <= empty_next;
            fx_first_reg <= XW'(cl);
            fx_last_reg  <= XW'(cr - S_ONE);
            fy_first_reg <= YW'(ct);
            fy_last_reg  <= YW'(cb - S_ONE);
        end
    end

    // Walk the pixels: column inner, row outer
    assign step    = cmd.copy_step || cmd.fill_step;
    assign row_end = (x_reg == x_last_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.init_fill)
        begin
            x_reg       <= fx_first_reg;
            x_first_reg <= fx_first_reg;
            x_last_reg  <= fx_last_reg;
            y_reg       <= fy_first_reg;
            src_y_reg   <= fy_first_reg;
            y_last_reg  <= fy_last_reg;
            down_reg    <= 1'b0;
        end
        else if (cmd.init_copy)
        begin
            x_reg       <= '0;
            x_first_reg <= '0;
            x_last_reg  <= cx_last_reg;
            y_reg       <= copy_y_first_reg;
            src_y_reg   <= copy_src_first_reg;
            y_last_reg  <= copy_y_last_reg;
            down_reg    <= copy_down_reg;
        end
        else if (step)
        begin
            if (row_end)
            begin
                x_reg <= x_first_reg;
                if (down_reg)
                begin
                    y_reg     <= y_reg - YW'(1);
                    src_y_reg <= src_y_reg - YW'(1);
                end
                else
                begin
                    y_reg     <= y_reg + YW'(1);
                    src_y_reg <= src_y_reg + YW'(1);
                end
            end
            else
            begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    // Issue writes through the stage; a copy takes its data from the read port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg       <= 1'b0;
            wr_from_ram_reg <= 1'b0;
            clear_addr_reg  <= '0;
        end
        else
        begin
            wr_en_reg       <= cmd.clear_step || step;
            wr_from_ram_reg <= cmd.copy_step;
            if (cmd.clear_step)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            wr_addr_reg <= clear_addr_reg;
            wr_data_reg <= '0;
        end
        else
        begin
            wr_addr_reg <= pix_addr(y_reg, x_reg);
            wr_data_reg <= colour_reg;
        end
    end

    assign ram_we    = wr_en_reg;
    assign ram_waddr = wr_addr_reg;
    assign ram_wdata = wr_from_ram_reg ? ram_rdata : wr_data_reg;
    assign ram_raddr = pix_addr(src_y_reg, x_reg);

    // Build the result
    always_ff @(posedge clk)
    begin
        if (cmd.res_init)
        begin
            res_colour_reg <= '0;
            res_empty_reg  <= empty_reg;
        end
        else if (cmd.cap_read)
        begin
            res_colour_reg <= ram_rdata;
        end
    end

    assign read_red          = res_colour_reg[3*fbsf_pkg::CHAN_W-1:2*fbsf_pkg::CHAN_W];
    assign read_green        = res_colour_reg[2*fbsf_pkg::CHAN_W-1:fbsf_pkg::CHAN_W];
    assign read_blue         = res_colour_reg[fbsf_pkg::CHAN_W-1:0];
    assign was_clipped_empty = res_empty_reg;

    // Report to the controller
    always_comb
    begin
        status.clear_done = (clear_addr_reg == AW'(DEPTH - 1));
        status.empty      = empty_reg;
        status.is_read    = (op_reg == fbsf_pkg::OP_READ);
        status.has_copy   = has_copy_reg;
        status.last       = row_end && (y_reg == y_last_reg);
    end

endmodule

FILE: hdl/framebuffer_scroll_fill_top.sv
// ============================================================================
// framebuffer_scroll_fill_top: frame-store blit engine (pixel, fill, vscroll)
// Commands: one at a time; the input stays stalled from accept until the
// result word is taken.
// Reset: the store is zeroed by a sweep of every entry, input stalled.
// ============================================================================
module framebuffer_scroll_fill_top #(
    parameter int MAX_WIDTH  = fbsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration port
    input  logic                                 cfg_write,
    input  logic [fbsf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fbsf_pkg::CFG_W-1:0]           cfg_data,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           command,
    input  logic signed [fbsf_pkg::COORD_W-1:0]  left_or_x,
    input  logic signed [fbsf_pkg::COORD_W-1:0]  top_or_y,
    input  logic signed [fbsf_pkg::COORD_W-1:0]  right_edge,
    input  logic signed [fbsf_pkg::COORD_W-1:0]  bottom_edge,
    input  logic signed [fbsf_pkg::COORD_W-1:0]  scroll_rows,
    input  logic [fbsf_pkg::CHAN_W-1:0]          red,
    input  logic [fbsf_pkg::CHAN_W-1:0]          green,
    input  logic [fbsf_pkg::CHAN_W-1:0]          blue,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fbsf_pkg::CHAN_W-1:0]          read_red,
    output logic [fbsf_pkg::CHAN_W-1:0]          read_green,
    output logic [fbsf_pkg::CHAN_W-1:0]          read_blue,
    output logic                                 was_clipped_empty
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    fbsf_pkg::ctrl_cmd_t          cmd;
    fbsf_pkg::dp_status_t         status;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [AW-1:0]                ram_raddr;
    logic [fbsf_pkg::PIXEL_W-1:0] ram_wdata;
    logic [fbsf_pkg::PIXEL_W-1:0] ram_rdata;

    // Sequencer
    fbsf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Plan, counters and store access
    fbsf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .command           (command),
        .left_or_x         (left_or_x),
        .top_or_y          (top_or_y),
        .right_edge        (right_edge),
        .bottom_edge       (bottom_edge),
        .scroll_rows       (scroll_rows),
        .red               (red),
        .green             (green),
        .blue              (blue),
        .read_red          (read_red),
        .read_green        (read_green),
        .read_blue         (read_blue),
        .was_clipped_empty (was_clipped_empty),
        .cmd               (cmd),
        .status            (status),
        .ram_we            (ram_we),
        .ram_waddr         (ram_waddr),
        .ram_wdata         (ram_wdata),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata)
    );

    // Frame store
    fbsf_ram #(
        .DATA_W (fbsf_pkg::PIXEL_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // No new word is taken while a result waits
    a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    // An empty command reports a zero colour
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_clipped_empty) |->
            (read_red == '0 && read_green == '0 && read_blue == '0))
        else $error("empty command returned a colour");

    // All store writes of the previous command have drained at accept
    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !ram_we)
        else $error("store write pending after accept");
`endif

endmodule
